FILE: hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CMD_W    = 4;
   localparam int DIN_W    = 32;
   localparam int DOUT_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam int CMDQ_DEPTH = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK   = 4'd0,
      CMD_PUSH_FRONT  = 4'd1,
      CMD_POP_BACK    = 4'd2,
      CMD_POP_FRONT   = 4'd3,
      CMD_READ_BACK   = 4'd4,
      CMD_READ_FRONT  = 4'd5,
      CMD_WRITE_BACK  = 4'd6,
      CMD_WRITE_FRONT = 4'd7,
      CMD_CLEAR       = 4'd8
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,
      OP_PUSH  = 3'd1,
      OP_POP   = 3'd2,
      OP_READ  = 3'd3,
      OP_WRITE = 3'd4,
      OP_CLEAR = 3'd5
   } opk_type;

   typedef struct packed {
      opk_type          kind;
      logic             at_front;
      logic [DIN_W-1:0] data;
   } op_type;

endpackage

FILE: hdl/double_ended_queue_top.sv
// Top level of the bounded double-ended queue.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; req_command selects push, pop, read or write at either end,
// or clear, and req_data_in carries the value for push and write.
// Result channel: rsp_valid is high for one cycle per command, with
// rsp_data_out (value popped or read, else zero), rsp_status (ok, empty,
// full) and rsp_count (entries after the command). Results leave in order.
// An accepted command is held in the command queue and then executed in
// the execute stage, whose storage read is registered; the result strobe
// and the result values come from the execute stage's registers.
// Throughput: one command per cycle; the execute stage retires one command
// each cycle from the two-entry command queue, so busy stays low in use.
// Reset clears head and count (empty queue), the command queue and the
// result strobe; stored values are not cleared. The receiver cannot stall
// and must take each result in the cycle it is shown.
module double_ended_queue_top #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [deq_pkg::CMD_W-1:0]      req_command,
   input  logic [deq_pkg::DIN_W-1:0]      req_data_in,
   output logic                           rsp_valid,
   output logic [deq_pkg::DOUT_W-1:0]     rsp_data_out,
   output logic [deq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [deq_pkg::COUNT_W-1:0]    rsp_count
);

   logic            op_valid;
   deq_pkg::op_type op;

   deq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .command  (req_command),
      .data_in  (req_data_in),
      .busy     (busy),
      .op_valid (op_valid),
      .op       (op)
   );

   deq_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .op_valid     (op_valid),
      .op           (op),
      .rsp_valid    (rsp_valid),
      .rsp_data_out (rsp_data_out),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

endmodule

FILE: hdl/deq_front.sv
// Command intake: accepts transactions, decodes them and buffers them in a short queue.
module deq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [deq_pkg::CMD_W-1:0]     command,
   input  logic [deq_pkg::DIN_W-1:0]     data_in,
   output logic                          busy,
   output logic                          op_valid,
   output deq_pkg::op_type               op
);

   localparam int QPW = (deq_pkg::CMDQ_DEPTH > 1) ? $clog2(deq_pkg::CMDQ_DEPTH) : 1;
   localparam int QCW = $clog2(deq_pkg::CMDQ_DEPTH + 1);

   deq_pkg::op_type q_ff [deq_pkg::CMDQ_DEPTH];
   logic [QPW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]  qcnt_ff, qcnt_in;

   deq_pkg::op_type dec_op;
   logic            push;
   logic            pop;

   always_comb begin
      dec_op.data     = data_in;
      dec_op.at_front = command[0];
      unique case (command)
         deq_pkg::CMD_PUSH_BACK,  deq_pkg::CMD_PUSH_FRONT:  dec_op.kind = deq_pkg::OP_PUSH;
         deq_pkg::CMD_POP_BACK,   deq_pkg::CMD_POP_FRONT:   dec_op.kind = deq_pkg::OP_POP;
         deq_pkg::CMD_READ_BACK,  deq_pkg::CMD_READ_FRONT:  dec_op.kind = deq_pkg::OP_READ;
         deq_pkg::CMD_WRITE_BACK, deq_pkg::CMD_WRITE_FRONT: dec_op.kind = deq_pkg::OP_WRITE;
         deq_pkg::CMD_CLEAR:                                dec_op.kind = deq_pkg::OP_CLEAR;
         default:                                           dec_op.kind = deq_pkg::OP_NOP;
      endcase
   end

   assign busy     = (qcnt_ff == QCW'(deq_pkg::CMDQ_DEPTH));
   assign push     = start && !busy;
   assign op_valid = (qcnt_ff != '0);
   assign pop      = op_valid;
   assign op       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      qcnt_in   = qcnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(deq_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + QPW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(deq_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + QPW'(1);
      end
      if (push && !pop) begin
         qcnt_in = qcnt_ff + QCW'(1);
      end else if (pop && !push) begin
         qcnt_in = qcnt_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         qcnt_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         qcnt_ff   <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec_op;
      end
   end

endmodule

FILE: hdl/deq_back.sv
// Execution side: ring buffer storage, head and count update, result register.
module deq_back #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           op_valid,
   input  deq_pkg::op_type                op,
   output logic                           rsp_valid,
   output logic [deq_pkg::DOUT_W-1:0]     rsp_data_out,
   output logic [deq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [deq_pkg::COUNT_W-1:0]    rsp_count
);

   localparam int HW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [HW-1:0] head_ff, head_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff;
   logic          rd_flag_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   deq_pkg::status_type   status_ff, status_in;

   logic [SW-1:0] tail_sum, back_sum;
   logic [HW-1:0] tail_slot, back_slot, head_dec, head_inc, end_slot;
   logic          empty, full;
   logic          wr_en, rd_en;
   logic [HW-1:0] wr_slot, rd_slot;

   logic [DATA_WIDTH+deq_pkg::DIN_W-1:0]  din_wide;
   logic [DATA_WIDTH-1:0]                 wr_data;
   logic [deq_pkg::DOUT_W+DATA_WIDTH-1:0] dout_wide;
   logic [deq_pkg::COUNT_W+CW-1:0]        cnt_wide;

   assign din_wide = {{DATA_WIDTH{1'b0}}, op.data};
   assign wr_data  = din_wide[DATA_WIDTH-1:0];

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == CW'(DEPTH));

   assign tail_sum  = SW'(head_ff) + SW'(cnt_ff);
   assign back_sum  = tail_sum - SW'(1);
   assign tail_slot = (tail_sum >= SW'(DEPTH)) ? HW'(tail_sum - SW'(DEPTH)) : HW'(tail_sum);
   assign back_slot = (back_sum >= SW'(DEPTH)) ? HW'(back_sum - SW'(DEPTH)) : HW'(back_sum);
   assign head_dec  = (head_ff == '0) ? HW'(DEPTH - 1) : head_ff - HW'(1);
   assign head_inc  = (head_ff == HW'(DEPTH - 1)) ? '0 : head_ff + HW'(1);
   assign end_slot  = op.at_front ? head_ff : back_slot;

   always_comb begin
      head_in   = head_ff;
      cnt_in    = cnt_ff;
      wr_en     = 1'b0;
      wr_slot   = tail_slot;
      rd_en     = 1'b0;
      rd_slot   = end_slot;
      status_in = deq_pkg::ST_OK;
      if (op_valid) begin
         unique case (op.kind)
            deq_pkg::OP_PUSH: begin
               if (full) begin
                  status_in = deq_pkg::ST_FULL;
               end else begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
                  if (op.at_front) begin
                     wr_slot = head_dec;
                     head_in = head_dec;
                  end
               end
            end
            deq_pkg::OP_POP, deq_pkg::OP_READ, deq_pkg::OP_WRITE: begin
               if (empty) begin
                  status_in = deq_pkg::ST_EMPTY;
               end else if (op.kind == deq_pkg::OP_WRITE) begin
                  wr_en   = 1'b1;
                  wr_slot = end_slot;
               end else begin
                  rd_en = 1'b1;
                  if (op.kind == deq_pkg::OP_POP) begin
                     cnt_in = cnt_ff - CW'(1);
                     if (op.at_front) begin
                        head_in = head_inc;
                     end
                  end
               end
            end
            deq_pkg::OP_CLEAR: begin
               head_in = '0;
               cnt_in  = '0;
            end
            deq_pkg::OP_NOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= op_valid;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      rd_flag_ff <= rd_en;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_slot];
      end
   end

   assign dout_wide = {{deq_pkg::DOUT_W{1'b0}}, rd_data_ff};
   assign cnt_wide  = {{deq_pkg::COUNT_W{1'b0}}, cnt_ff};

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rd_flag_ff ? dout_wide[deq_pkg::DOUT_W-1:0] : '0;
   assign rsp_status   = status_ff;
   assign rsp_count    = cnt_wide[deq_pkg::COUNT_W-1:0];

endmodule
